[src/epe_pkg.sv]
// Shared types and constants for the edge pair enumerator.
`default_nettype none
package epe_pkg;

   // Fixed port widths
   localparam int NODE_W  = 6;
   localparam int COUNT_W = 7;
   localparam int OP_W    = 2;

   // Operation codes
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
   localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

   // Node count after reset
   localparam logic [COUNT_W-1:0] NODE_COUNT_RST = 7'd64;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ADD_WR,
      ST_Q_LOAD,
      ST_SCAN
   } state_type;

endpackage
`default_nettype wire

[src/epe_ram.sv]
// Generic single write port, single read port RAM with registered, write-first read.
`default_nettype none
module epe_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port; a read of the word being written
   // returns the new data
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= (we && (waddr == raddr)) ? wdata : mem[raddr];
   end

endmodule
`default_nettype wire

[src/edge_pair_enumerator.sv]
// Top level of the edge pair enumerator: adjacency store and scan sequencer.
//
// Usage:
//   A transaction is taken at a rising edge with start high and busy low.
//   req_op selects clear graph, add edge req_src_node->req_dst_node, or query
//   edge pairs from first node req_src_node to last node req_dst_node.
//   Rows and columns of the adjacency matrix live in two RAMs; a per-entry
//   valid flag makes a never-written or cleared entry read as zero.
//   Clear and unused op codes keep the block in idle; busy stays low.
//   Add edge: read row and column, then write them back in ST_ADD_WR.
//   Query: the row and column are read, then masked in ST_Q_LOAD, then one
//   bit of the middle-node mask is tested per cycle in ST_SCAN by a shifting
//   scan that stops after the highest set bit.
//   With no pair, ST_Q_LOAD gives a single result with found 0 and returns to idle.
//   Results appear on rsp_* for one cycle each, flagged by rsp_strobe, in
//   ascending middle node order; rsp_run_end marks the last one. The
//   receiver cannot stall the block.
//   csr_write_en/csr_write_data set node_count; write only while idle.
//   Reset (synchronous) empties the graph, sets node_count to 64 and returns
//   to idle; no clearing pass is needed.
`default_nettype none
module edge_pair_enumerator
   import epe_pkg::*;
#(
   parameter int NODES = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [OP_W-1:0]    req_op,
   input  wire logic [NODE_W-1:0]  req_src_node,
   input  wire logic [NODE_W-1:0]  req_dst_node,
   input  wire logic               csr_write_en,
   input  wire logic [COUNT_W-1:0] csr_write_data,
   output logic                    rsp_strobe,
   output logic      [NODE_W-1:0]  rsp_first_node,
   output logic      [NODE_W-1:0]  rsp_middle_node,
   output logic      [NODE_W-1:0]  rsp_last_node,
   output logic                    rsp_found,
   output logic                    rsp_run_end
);

   localparam int NW = $clog2(NODES);
   localparam logic [NODES-1:0] ONE = NODES'(1);

   state_type            state_ff, state_in;
   logic [NODE_W-1:0]    a_ff, a_in, b_ff, b_in;
   logic [NODES-1:0]     mask_ff, mask_in;
   logic [NW-1:0]        k_ff, k_in;
   logic [NODES-1:0]     rows_vld_ff, rows_vld_in, cols_vld_ff, cols_vld_in;
   logic                 row_vq_ff, col_vq_ff;
   logic [COUNT_W-1:0]   node_count_ff;
   logic                 strobe_ff, strobe_in;
   logic [NODE_W-1:0]    mid_ff, mid_in;
   logic                 found_ff, found_in, end_ff, end_in;

   logic [NW-1:0]        row_raddr, col_raddr;
   logic [NODES-1:0]     row_rdata, col_rdata, row_word, col_word;
   logic                 ram_we;
   logic [NODES-1:0]     row_wdata, col_wdata;
   logic [COUNT_W-1:0]   lim;
   logic [NODES-1:0]     act_mask;
   logic                 query_ok;
   logic                 req_in_range;

   // adjacency storage
   epe_ram #(.WIDTH(NODES), .DEPTH(NODES)) u_rows (
      .clock    (clock),
      .we       (ram_we),
      .waddr    (a_ff[NW-1:0]),
      .wdata    (row_wdata),
      .raddr    (row_raddr),
      .rdata_ff (row_rdata)
   );

   epe_ram #(.WIDTH(NODES), .DEPTH(NODES)) u_cols (
      .clock    (clock),
      .we       (ram_we),
      .waddr    (b_ff[NW-1:0]),
      .wdata    (col_wdata),
      .raddr    (col_raddr),
      .rdata_ff (col_rdata)
   );

   // read addresses come straight from the request ports
   assign row_raddr = req_src_node[NW-1:0];
   assign col_raddr = req_dst_node[NW-1:0];

   // invalid entries read as empty
   assign row_word = row_vq_ff ? row_rdata : '0;
   assign col_word = col_vq_ff ? col_rdata : '0;

   assign row_wdata = row_word | (ONE << b_ff[NW-1:0]);
   assign col_wdata = col_word | (ONE << a_ff[NW-1:0]);

   // active node count saturates at NODES
   assign lim = (node_count_ff > COUNT_W'(NODES)) ? COUNT_W'(NODES) : node_count_ff;

   always_comb begin
      for (int i = 0; i < NODES; i++) begin
         act_mask[i] = COUNT_W'(i) < lim;
      end
   end

   assign query_ok = ({1'b0, a_ff} < lim) && ({1'b0, b_ff} < lim);

   assign req_in_range = ({1'b0, req_src_node} < COUNT_W'(NODES))
                      && ({1'b0, req_dst_node} < COUNT_W'(NODES));

   assign busy = (state_ff != ST_IDLE);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_vld_ff   <= '0;
         cols_vld_ff   <= '0;
         node_count_ff <= NODE_COUNT_RST;
         strobe_ff     <= 1'b0;
      end else begin
         rows_vld_ff <= rows_vld_in;
         cols_vld_ff <= cols_vld_in;
         strobe_ff   <= strobe_in;
         if (csr_write_en) begin
            node_count_ff <= csr_write_data;
         end
      end
   end

   // payload registers; valid flags are looked up including a write in progress
   always_ff @(posedge clock) begin
      a_ff      <= a_in;
      b_ff      <= b_in;
      mask_ff   <= mask_in;
      k_ff      <= k_in;
      row_vq_ff <= rows_vld_in[row_raddr];
      col_vq_ff <= cols_vld_in[col_raddr];
      mid_ff    <= mid_in;
      found_ff  <= found_in;
      end_ff    <= end_in;
   end

   // sequencer: next state and datapath control
   always_comb begin
      state_in    = state_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      mask_in     = mask_ff;
      k_in        = k_ff;
      rows_vld_in = rows_vld_ff;
      cols_vld_in = cols_vld_ff;
      ram_we      = 1'b0;
      strobe_in   = 1'b0;
      mid_in      = mid_ff;
      found_in    = found_ff;
      end_in      = end_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               a_in = req_src_node;
               b_in = req_dst_node;
               case (req_op)
                  OP_CLEAR: begin
                     rows_vld_in = '0;
                     cols_vld_in = '0;
                  end
                  OP_ADD: begin
                     if (req_in_range) begin
                        state_in = ST_ADD_WR;
                     end
                  end
                  OP_QUERY: begin
                     state_in = ST_Q_LOAD;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_ADD_WR: begin
            // write back row and column with the new edge set
            ram_we                      = 1'b1;
            rows_vld_in[a_ff[NW-1:0]]   = 1'b1;
            cols_vld_in[b_ff[NW-1:0]]   = 1'b1;
            state_in                    = ST_IDLE;
         end

         ST_Q_LOAD: begin
            // intersect row of first with column of last
            mask_in = query_ok ? (row_word & col_word & act_mask) : '0;
            k_in    = '0;
            if (mask_in == '0) begin
               strobe_in = 1'b1;
               mid_in    = '0;
               found_in  = 1'b0;
               end_in    = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               state_in = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // test one bit per cycle, shift the rest down
            mask_in = mask_ff >> 1;
            k_in    = k_ff + NW'(1);
            if (mask_ff[0]) begin
               strobe_in = 1'b1;
               mid_in    = NODE_W'(k_ff);
               found_in  = 1'b1;
               end_in    = (mask_in == '0);
               if (mask_in == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response ports
   assign rsp_strobe      = strobe_ff;
   assign rsp_first_node  = a_ff;
   assign rsp_last_node   = b_ff;
   assign rsp_middle_node = mid_ff;
   assign rsp_found       = found_ff;
   assign rsp_run_end     = end_ff;

endmodule
`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for the edge pair enumerator: graph commands in, edge pairs checked.
module testbench;
   import epe_pkg::*;

   localparam int GRAPH_NODES = 64;
   localparam int DRAIN_CYCLES = GRAPH_NODES + 4;
   localparam int WATCHDOG_LIMIT = 2000;
   // Op code the block leaves unused
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [NODE_W-1:0] src;
      logic [NODE_W-1:0] dst;
   } graph_cmd_t;

   typedef struct packed {
      logic [NODE_W-1:0] first;
      logic [NODE_W-1:0] middle;
      logic [NODE_W-1:0] last;
      logic              found;
      logic              run_end;
   } edge_pair_t;

   logic                clock;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic [OP_W-1:0]     req_op = OP_CLEAR;
   logic [NODE_W-1:0]   req_src_node = '0;
   logic [NODE_W-1:0]   req_dst_node = '0;
   logic                csr_write_en = 1'b0;
   logic [COUNT_W-1:0]  csr_write_data = '0;
   logic                busy;
   logic                rsp_strobe;
   logic [NODE_W-1:0]   rsp_first_node;
   logic [NODE_W-1:0]   rsp_middle_node;
   logic [NODE_W-1:0]   rsp_last_node;
   logic                rsp_found;
   logic                rsp_run_end;

   // Stimulus queue, expected pairs and bookkeeping
   graph_cmd_t          pending_cmds[$];
   edge_pair_t          expected_pairs[$];
   int                  cmds_queued = 0;
   int                  cmds_taken = 0;
   int                  error_count = 0;
   int                  idle_cycles = 0;
   int unsigned         send_gap_pct = 37;

   // Shadow copy of the graph and the node count register
   logic [GRAPH_NODES-1:0] shadow_rows[GRAPH_NODES];
   logic [GRAPH_NODES-1:0] shadow_cols[GRAPH_NODES];
   logic [COUNT_W-1:0]     shadow_node_count = NODE_COUNT_RST;

   edge_pair_enumerator #(.NODES(GRAPH_NODES)) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_src_node    (req_src_node),
      .req_dst_node    (req_dst_node),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data),
      .rsp_strobe      (rsp_strobe),
      .rsp_first_node  (rsp_first_node),
      .rsp_middle_node (rsp_middle_node),
      .rsp_last_node   (rsp_last_node),
      .rsp_found       (rsp_found),
      .rsp_run_end     (rsp_run_end)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      for (int i = 0; i < GRAPH_NODES; i++) begin
         shadow_rows[i] = '0;
         shadow_cols[i] = '0;
      end
   end

   // Apply one accepted command to the shadow graph and queue the pairs it yields
   function automatic void predict_edge_pairs(graph_cmd_t cmd);
      int unsigned active;
      logic [GRAPH_NODES-1:0] middles;
      logic [GRAPH_NODES-1:0] use_mask;
      edge_pair_t pair;
      active = (shadow_node_count > GRAPH_NODES) ? GRAPH_NODES : shadow_node_count;
      use_mask = (active >= GRAPH_NODES) ? '1 : ((64'd1 << active) - 64'd1);
      case (cmd.op)
         OP_CLEAR: begin
            for (int i = 0; i < GRAPH_NODES; i++) begin
               shadow_rows[i] = '0;
               shadow_cols[i] = '0;
            end
         end
         OP_ADD: begin
            shadow_rows[cmd.src][cmd.dst] = 1'b1;
            shadow_cols[cmd.dst][cmd.src] = 1'b1;
         end
         OP_QUERY: begin
            middles = '0;
            if (cmd.src < active && cmd.dst < active)
               middles = shadow_rows[cmd.src] & shadow_cols[cmd.dst] & use_mask;
            pair.first = cmd.src;
            pair.last = cmd.dst;
            if (middles == '0) begin
               pair.middle = '0;
               pair.found = 1'b0;
               pair.run_end = 1'b1;
               expected_pairs.insert(expected_pairs.size(), pair);
            end else begin
               // one pair per middle node, lowest first
               for (int k = 0; k < GRAPH_NODES; k++) begin
                  if (middles[k]) begin
                     middles[k] = 1'b0;
                     pair.middle = k[NODE_W-1:0];
                     pair.found = 1'b1;
                     pair.run_end = (middles == '0);
                     expected_pairs.insert(expected_pairs.size(), pair);
                  end
               end
            end
         end
         default: ;  // unused op: no effect
      endcase
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endfunction

   // Driver: holds start until the transaction is taken, idles at random
   always @(posedge clock) begin : drive_cmds
      graph_cmd_t next_cmd;
      logic taken;
      if (reset) begin
         start <= 1'b0;
      end else begin
         taken = start && !busy;
         if (taken) begin
            predict_edge_pairs('{op: req_op, src: req_src_node, dst: req_dst_node});
            cmds_taken++;
         end
         if (taken || !start) begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
               next_cmd = pending_cmds.pop_front();
               start <= 1'b1;
               req_op <= next_cmd.op;
               req_src_node <= next_cmd.src;
               req_dst_node <= next_cmd.dst;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every strobed result against the oldest expected pair
   always @(posedge clock) begin : check_pairs
      edge_pair_t want;
      if (!reset && rsp_strobe) begin
         if (expected_pairs.size() == 0) begin
            $error("unexpected result: first %0d middle %0d last %0d found %0d end %0d",
                   rsp_first_node, rsp_middle_node, rsp_last_node, rsp_found,
                   rsp_run_end);
            error_count++;
         end else begin
            want = expected_pairs.pop_front();
            check_field("first_node", want.first, rsp_first_node);
            check_field("middle_node", want.middle, rsp_middle_node);
            check_field("last_node", want.last, rsp_last_node);
            check_field("found", want.found, rsp_found);
            check_field("run_end", want.run_end, rsp_run_end);
         end
      end
   end

   // Watchdog on cycles with no transaction either way
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("testbench failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic push_cmd(logic [OP_W-1:0] op, logic [NODE_W-1:0] src,
                           logic [NODE_W-1:0] dst);
      graph_cmd_t cmd;
      cmd = '{op: op, src: src, dst: dst};
      pending_cmds.insert(pending_cmds.size(), cmd);
      cmds_queued++;
   endtask

   // Mostly adds and queries over nodes below span, with clears and unused ops as noise
   task automatic push_random_cmds(int count, int unsigned span);
      int unsigned pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 3)
            push_cmd(OP_CLEAR, NODE_W'($urandom_range(63)), NODE_W'($urandom_range(63)));
         else if (pick < 8)
            push_cmd(OP_UNUSED, NODE_W'($urandom_range(63)), NODE_W'($urandom_range(63)));
         else if (pick < 55)
            push_cmd(OP_ADD, NODE_W'($urandom_range(span - 1)),
                     NODE_W'($urandom_range(span - 1)));
         else
            push_cmd(OP_QUERY, NODE_W'($urandom_range(span - 1)),
                     NODE_W'($urandom_range(span - 1)));
      end
   endtask

   // Wait until every command is taken and every pair has come, then let the block settle
   task automatic wait_drained();
      while (cmds_taken != cmds_queued || expected_pairs.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_node_count(logic [COUNT_W-1:0] value);
      wait_drained();
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      shadow_node_count = value;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty graph, extreme nodes, self loops, duplicates, clear, unused op
      send_gap_pct = 37;
      push_cmd(OP_QUERY, 0, 0);
      push_cmd(OP_ADD, 0, 63);
      push_cmd(OP_ADD, 63, 63);
      push_cmd(OP_ADD, 63, 0);
      push_cmd(OP_ADD, 0, 0);
      push_cmd(OP_ADD, 0, 5);
      push_cmd(OP_ADD, 5, 63);
      push_cmd(OP_ADD, 0, 5);
      push_cmd(OP_QUERY, 0, 63);
      push_cmd(OP_QUERY, 63, 0);
      push_cmd(OP_QUERY, 63, 63);
      push_cmd(OP_QUERY, 5, 5);
      push_cmd(OP_UNUSED, 63, 63);
      push_cmd(OP_UNUSED, 0, 0);
      push_cmd(OP_QUERY, 0, 63);
      push_cmd(OP_CLEAR, 63, 63);
      push_cmd(OP_QUERY, 0, 63);
      push_cmd(OP_ADD, 21, 42);
      push_cmd(OP_ADD, 42, 21);
      push_cmd(OP_QUERY, 21, 21);
      push_cmd(OP_QUERY, 42, 42);

      // One node in use: only node 0 can take part
      write_node_count(7'd1);
      push_cmd(OP_ADD, 0, 0);
      push_cmd(OP_QUERY, 0, 0);
      push_cmd(OP_QUERY, 0, 1);
      push_cmd(OP_QUERY, 21, 21);
      push_random_cmds(20, 3);

      // Count above the node limit saturates; longest query run
      write_node_count(7'd127);
      send_gap_pct = 76;
      for (int k = 0; k < GRAPH_NODES; k += 2) begin
         push_cmd(OP_ADD, 1, NODE_W'(k));
         push_cmd(OP_ADD, NODE_W'(k), 62);
      end
      push_cmd(OP_ADD, 1, 63);
      push_cmd(OP_ADD, 63, 62);
      push_cmd(OP_QUERY, 1, 62);
      push_cmd(OP_QUERY, 62, 1);
      push_cmd(OP_QUERY, 1, 62);

      // Partial count: stored edges above it must drop out
      write_node_count(7'd40);
      push_cmd(OP_QUERY, 1, 62);
      push_cmd(OP_QUERY, 1, 30);
      push_random_cmds(60, 48);

      // No node in use: every query answers found 0
      write_node_count(7'd0);
      send_gap_pct = 0;
      push_random_cmds(15, 4);

      write_node_count(7'd8);
      send_gap_pct = 37;
      push_cmd(OP_CLEAR, 0, 0);
      push_random_cmds(40, 10);

      write_node_count(7'd64);
      send_gap_pct = 76;
      push_random_cmds(30, 64);
      push_random_cmds(40, 8);

      write_node_count(7'd100);
      send_gap_pct = 0;
      push_random_cmds(30, 12);

      wait_drained();
      if (error_count == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
